FILE: rtl/core/text_cell_buffer_dirty_rects_top_assert.svh
// Assertion macros for the text cell buffer block.
`ifndef TEXT_CELL_BUFFER_DIRTY_RECTS_TOP_ASSERT_SVH
`define TEXT_CELL_BUFFER_DIRTY_RECTS_TOP_ASSERT_SVH
`ifndef SYNTH
`define TCB_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define TCB_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define TCB_ASSERT_IMPL(label, clk, rst_n, a, c)
`define TCB_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/core/tcb_pkg.sv
// Shared constants and types for the text cell buffer block.
package tcb_pkg;
	localparam int COLUMNS = 32;
	localparam int ROWS = 24;
	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW = $clog2(CELLS);
	localparam int CW = 6;
	localparam int RW = 6;
	localparam logic [1:0] MODE_PUT = 2'd0;
	localparam logic [1:0] MODE_CUR = 2'd1;
	localparam logic [1:0] MODE_FIND = 2'd2;
	localparam logic [1:0] MODE_CLR = 2'd3;
	localparam logic CFG_FG = 1'b0;
	localparam logic CFG_BG = 1'b1;
	localparam logic [7:0] CHAR_BASE = 8'd32;
	typedef logic [AW-1:0] addr_t;
endpackage

FILE: rtl/core/tcb_ram.sv
// Generic single-port synchronous RAM with registered read.
module tcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle; read data is registered and appears in the cycle after the address.
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

FILE: rtl/core/text_cell_buffer_dirty_rects_top.sv
// Top level of the text cell buffer with dirty rectangle tracking.
// Usage: an input beat on in_valid/in_ready carries mode, char_code, cursor
// fields and clear_attribute. Put char and set cursor give no result; find
// dirty and clear give one result beat on out_valid/out_ready.
// Glyph and attribute sit in one RAM word per cell, and the dirty mark sits in
// a second RAM at the same address; both have a registered read, and
// one cell is touched per cycle at most.
// Put char reads the cell, then compares and writes it (read, compare, write).
// Clear writes every cell. Find dirty scans cells, each cell read and then
// tested (and written back where its mark is cleared), then grows the
// rectangle; the single address shared by both RAMs serializes these steps.
// After reset a clearing pass writes all 768 cells to zero while in_ready
// stays low; configuration writes are taken at any time.
// A result waits in the output register while the receiver stalls, and the
// block takes no new item until that result is taken.
// fg_color resets to 15, bg_color to 0.
module text_cell_buffer_dirty_rects_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] mode,
	input logic [7:0] char_code,
	input logic [7:0] cursor_column,
	input logic [7:0] cursor_row,
	input logic [7:0] clear_attribute,
	output logic out_valid,
	input logic out_ready,
	output logic found,
	output logic [5:0] rect_column,
	output logic [5:0] rect_row,
	output logic [6:0] rect_width,
	output logic [6:0] rect_height,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [3:0] cfg_data
);
	import tcb_pkg::*;

	localparam logic [3:0] ST_INIT = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_PRD = 4'd2;
	localparam logic [3:0] ST_PWR = 4'd3;
	localparam logic [3:0] ST_CLR = 4'd4;
	localparam logic [3:0] ST_SRD = 4'd5;
	localparam logic [3:0] ST_STST = 4'd6;
	localparam logic [3:0] ST_DRD = 4'd7;
	localparam logic [3:0] ST_DTST = 4'd8;
	localparam logic [3:0] ST_RRD = 4'd9;
	localparam logic [3:0] ST_RTST = 4'd10;
	localparam logic [3:0] ST_CRD = 4'd11;
	localparam logic [3:0] ST_CTST = 4'd12;
	localparam logic [3:0] ST_CWR = 4'd13;
	localparam logic [3:0] ST_OUT = 4'd14;

	logic [3:0] state_q;
	logic [3:0] fg_q, bg_q;
	logic [7:0] ccol_q, crow_q;
	logic [AW-1:0] cnt_q;
	logic [7:0] char_q, attr_q;
	logic [5:0] left_q, top_q, r_q, c_q;
	logic [6:0] h_q, w_q;
	logic found_q;

	logic cell_we, dirty_we;
	addr_t addr;
	logic [15:0] cell_wdata, cell_rdata;
	logic dirty_wdata, dirty_rdata;

	tcb_ram #(.WIDTH(16), .DEPTH(CELLS)) u_cells (
		.clk(clk), .we(cell_we), .addr(addr), .wdata(cell_wdata), .rdata(cell_rdata)
	);

	tcb_ram #(.WIDTH(1), .DEPTH(CELLS)) u_dirty (
		.clk(clk), .we(dirty_we), .addr(addr), .wdata(dirty_wdata), .rdata(dirty_rdata)
	);

	logic cur_ok;
	logic put_chg;
	addr_t cur_addr, rc_addr;
	logic [7:0] new_g, new_a;
	assign cur_ok = (ccol_q < 8'(COLUMNS)) && (crow_q < 8'(ROWS));
	assign cur_addr = AW'(crow_q) * AW'(COLUMNS) + AW'(ccol_q);
	assign rc_addr = AW'(r_q) * AW'(COLUMNS) + AW'(c_q);
	assign new_g = char_q - CHAR_BASE;
	assign new_a = {fg_q, bg_q};
	assign put_chg = (char_q >= CHAR_BASE) &&
		(cell_rdata[7:0] != new_g || cell_rdata[15:8] != new_a);

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = (state_q == ST_OUT);
	assign found = found_q;
	assign rect_column = left_q;
	assign rect_row = top_q;
	assign rect_width = w_q;
	assign rect_height = h_q;

	// RAM port control per state.
	always_comb begin
		cell_we = 1'b0;
		dirty_we = 1'b0;
		addr = cnt_q;
		cell_wdata = '0;
		dirty_wdata = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cell_we = 1'b1;
				dirty_we = 1'b1;
			end
			// Clear rewrites glyphs and attributes only; dirty marks stay.
			ST_CLR: begin
				cell_we = 1'b1;
				cell_wdata = {attr_q, 8'd0};
			end
			ST_PRD: addr = cur_addr;
			ST_PWR: begin
				addr = cur_addr;
				cell_we = put_chg;
				dirty_we = put_chg;
				cell_wdata = {new_a, new_g};
				dirty_wdata = 1'b1;
			end
			ST_SRD, ST_STST: addr = cnt_q;
			ST_DRD, ST_RRD, ST_CRD: addr = rc_addr;
			ST_DTST: begin
				addr = rc_addr;
				dirty_we = dirty_rdata;
			end
			ST_RTST, ST_CTST: addr = rc_addr;
			ST_CWR: begin
				addr = rc_addr;
				dirty_we = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q <= '0;
			fg_q <= 4'd15;
			bg_q <= 4'd0;
			ccol_q <= '0;
			crow_q <= '0;
			char_q <= '0;
			attr_q <= '0;
			left_q <= '0;
			top_q <= '0;
			r_q <= '0;
			c_q <= '0;
			h_q <= '0;
			w_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_FG) fg_q <= cfg_data;
				else bg_q <= cfg_data;
			end
			unique case (state_q)
				ST_INIT, ST_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == AW'(CELLS - 1)) begin
						cnt_q <= '0;
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_OUT;
					end
				end
				ST_IDLE: if (in_valid) begin
					char_q <= char_code;
					attr_q <= clear_attribute;
					cnt_q <= '0;
					unique case (mode)
						MODE_PUT: if (cur_ok) state_q <= ST_PRD;
						MODE_CUR: begin
							ccol_q <= cursor_column;
							crow_q <= cursor_row;
						end
						MODE_FIND: state_q <= ST_SRD;
						default: begin
							ccol_q <= '0;
							crow_q <= '0;
							found_q <= 1'b1;
							left_q <= '0;
							top_q <= '0;
							w_q <= 7'(COLUMNS);
							h_q <= 7'(ROWS);
							state_q <= ST_CLR;
						end
					endcase
				end
				ST_PRD: state_q <= ST_PWR;
				ST_PWR: begin
					if (ccol_q + 8'd1 < 8'(COLUMNS)) ccol_q <= ccol_q + 8'd1;
					state_q <= ST_IDLE;
				end
				ST_SRD: state_q <= ST_STST;
				ST_STST: begin
					if (dirty_rdata) begin
						top_q <= 6'(cnt_q / AW'(COLUMNS));
						left_q <= 6'(cnt_q % AW'(COLUMNS));
						r_q <= 6'(cnt_q / AW'(COLUMNS));
						c_q <= 6'(cnt_q % AW'(COLUMNS));
						h_q <= 7'd0;
						w_q <= 7'd1;
						state_q <= ST_DRD;
					end else if (cnt_q == AW'(CELLS - 1)) begin
						found_q <= 1'b0;
						left_q <= '0;
						top_q <= '0;
						w_q <= '0;
						h_q <= '0;
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= ST_SRD;
					end
				end
				// Grow downward along the first column, clearing its dirty marks.
				ST_DRD: state_q <= ST_DTST;
				ST_DTST: begin
					if (dirty_rdata && 7'(r_q) + 7'd1 < 7'(ROWS)) begin
						h_q <= h_q + 7'd1;
						r_q <= r_q + 6'd1;
						state_q <= ST_DRD;
					end else begin
						if (dirty_rdata) h_q <= h_q + 7'd1;
						r_q <= top_q;
						c_q <= c_q + 6'd1;
						if (7'(c_q) + 7'd1 >= 7'(COLUMNS)) begin
							found_q <= 1'b1;
							state_q <= ST_OUT;
						end else state_q <= ST_RRD;
					end
				end
				// Check the next column over the rows found.
				ST_RRD: state_q <= ST_RTST;
				ST_RTST: begin
					if (!dirty_rdata) begin
						found_q <= 1'b1;
						state_q <= ST_OUT;
					end else if (7'(r_q) + 7'd1 < 7'(top_q) + h_q) begin
						r_q <= r_q + 6'd1;
						state_q <= ST_RRD;
					end else begin
						r_q <= top_q;
						state_q <= ST_CRD;
					end
				end
				// Column fully dirty: clear its marks.
				ST_CRD: state_q <= ST_CTST;
				ST_CTST: state_q <= ST_CWR;
				ST_CWR: begin
					if (7'(r_q) + 7'd1 < 7'(top_q) + h_q) begin
						r_q <= r_q + 6'd1;
						state_q <= ST_CRD;
					end else begin
						w_q <= w_q + 7'd1;
						r_q <= top_q;
						c_q <= c_q + 6'd1;
						if (7'(c_q) + 7'd1 >= 7'(COLUMNS)) begin
							found_q <= 1'b1;
							state_q <= ST_OUT;
						end else state_q <= ST_RRD;
					end
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "text_cell_buffer_dirty_rects_top_assert.svh"
	`TCB_ASSERT_NEXT(a_out_held, clk, arst_n, out_valid && !out_ready, $stable({found, rect_column, rect_row, rect_width, rect_height}))
	`TCB_ASSERT_NEXT(a_stall, clk, arst_n, out_valid && !out_ready, out_valid)
	`TCB_ASSERT_IMPL(a_excl, clk, arst_n, out_valid, !in_ready)
endmodule
